// ===== rtl/tbgb_pkg.sv =====
`timescale 1ns / 1ps
package tbgb_pkg;

  typedef enum logic [2:0] {
    OP_GLYPH_PIXEL  = 3'd0,
    OP_GLYPH_METRIC = 3'd1,
    OP_START_TEXT   = 3'd2,
    OP_DRAW_CHAR    = 3'd3,
    OP_READ_PIXEL   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_BOX_WIDTH     = 2'd0,
    CFG_BOX_HEIGHT    = 2'd1,
    CFG_FONT_ASCENDER = 2'd2,
    CFG_LINE_HEIGHT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_META,
    ST_DRAW,
    ST_FLUSH,
    ST_READ,
    ST_RESP
  } state_t;

  localparam logic [6:0] NEWLINE_CODE = 7'd10;
  localparam logic [7:0] LEVEL_ON     = 8'd255;
  localparam logic [9:0] POS_MAX      = 10'd1023;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;
    logic glyph_we;
    logic meta_we;
    logic text_reset;
    logic clear_step;
    logic newline;
    logic setup;
    logic draw_step;
    logic pen_adv;
    logic alpha_capture;
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] op;
    logic       newline_code;
    logic       clear_last;
    logic       draw_done;
  } stat_t;

endpackage

// ===== rtl/tbgb_ram.sv =====
`timescale 1ns / 1ps
module tbgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/tbgb_ctrl.sv =====
`timescale 1ns / 1ps
module tbgb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  tbgb_pkg::stat_t stat,
  output tbgb_pkg::ctl_t  ctl,
  output logic           busy,
  output logic           out_valid
);
  import tbgb_pkg::*;

  state_t state_r, state_nxt;
  logic   clr_op_r, clr_op_nxt;

  // State register; reset starts the surface clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_op_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_op_r <= clr_op_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    clr_op_nxt = clr_op_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clear_last) begin
          state_nxt = clr_op_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.op)
          OP_START_TEXT: begin
            state_nxt  = ST_CLEAR;
            clr_op_nxt = 1'b1;
          end
          OP_DRAW_CHAR: state_nxt = stat.newline_code ? ST_RESP : ST_META;
          OP_READ_PIXEL: state_nxt = ST_READ;
          default: state_nxt = ST_RESP;
        endcase
      end
      ST_META:  state_nxt = ST_DRAW;
      ST_DRAW: begin
        if (stat.draw_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_RESP;
      ST_READ:  state_nxt = ST_RESP;
      ST_RESP:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl       = '0;
    busy      = (state_r != ST_IDLE);
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: ctl.clear_step = 1'b1;
      ST_IDLE:  ctl.latch_in = start;
      ST_EXEC: begin
        case (stat.op)
          OP_GLYPH_PIXEL:  ctl.glyph_we = 1'b1;
          OP_GLYPH_METRIC: ctl.meta_we = 1'b1;
          OP_START_TEXT:   ctl.text_reset = 1'b1;
          OP_DRAW_CHAR:    ctl.newline = stat.newline_code;
          default: ;
        endcase
      end
      ST_META:  ctl.setup = 1'b1;
      ST_DRAW:  ctl.draw_step = !stat.draw_done;
      ST_FLUSH: ctl.pen_adv = 1'b1;
      ST_READ:  ctl.alpha_capture = 1'b1;
      ST_RESP:  out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== rtl/tbgb_datapath.sv =====
`timescale 1ns / 1ps
module tbgb_datapath #(
  parameter int GLYPH_COUNT    = 128,
  parameter int GLYPH_MAX_DIM  = 32,
  parameter int BOX_MAX_WIDTH  = 256,
  parameter int BOX_MAX_HEIGHT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tbgb_pkg::ctl_t       ctl,
  output tbgb_pkg::stat_t      stat,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [8:0]           cfg_data,
  input  logic [2:0]           in_op,
  input  logic [6:0]           in_code,
  input  logic [4:0]           in_glyph_col,
  input  logic [4:0]           in_glyph_row,
  input  logic [7:0]           in_alpha,
  input  logic [5:0]           in_glyph_width,
  input  logic [5:0]           in_glyph_height,
  input  logic [7:0]           in_advance,
  input  logic signed [7:0]    in_bearing_x,
  input  logic signed [7:0]    in_bearing_y,
  input  logic [7:0]           in_surface_col,
  input  logic [5:0]           in_surface_row,
  output logic [7:0]           pixel_alpha,
  output logic [9:0]           pen_position,
  output logic [9:0]           line_top
);
  import tbgb_pkg::*;

  localparam int GDEPTH = GLYPH_COUNT * GLYPH_MAX_DIM * GLYPH_MAX_DIM;
  localparam int SDEPTH = BOX_MAX_WIDTH * BOX_MAX_HEIGHT;
  localparam int GA_W   = $clog2(GDEPTH);
  localparam int SA_W   = $clog2(SDEPTH);
  localparam int MA_W   = $clog2(GLYPH_COUNT);
  localparam int DIM_W  = $clog2(GLYPH_MAX_DIM + 1);
  localparam int MW     = 2 * DIM_W + 24;
  localparam logic [SA_W-1:0] CLR_LAST = SA_W'(SDEPTH - 1);

  // Configuration registers
  logic [8:0] box_width_r;
  logic [6:0] box_height_r;
  logic [7:0] ascender_r, line_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r   <= 9'd256;
      box_height_r  <= 7'd64;
      ascender_r    <= 8'd0;
      line_height_r <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BOX_WIDTH:     box_width_r   <= cfg_data;
        CFG_BOX_HEIGHT:    box_height_r  <= cfg_data[6:0];
        CFG_FONT_ASCENDER: ascender_r    <= cfg_data[7:0];
        CFG_LINE_HEIGHT:   line_height_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective box limits, clamped to the surface size
  logic [10:0] wlim, hlim;
  assign wlim = (32'(box_width_r) > BOX_MAX_WIDTH) ? 11'(BOX_MAX_WIDTH) : 11'(box_width_r);
  assign hlim = (32'(box_height_r) > BOX_MAX_HEIGHT) ? 11'(BOX_MAX_HEIGHT)
                                                     : 11'(box_height_r);

  // Latched transaction fields
  logic [2:0]        op_r;
  logic [6:0]        code_r;
  logic [4:0]        gcol_r, grow_r;
  logic [7:0]        alpha_in_r, adv_in_r, scol_r;
  logic [5:0]        gw_r, gh_r, srow_r;
  logic signed [7:0] bx_in_r, by_in_r;

  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      op_r       <= in_op;
      code_r     <= in_code;
      gcol_r     <= in_glyph_col;
      grow_r     <= in_glyph_row;
      alpha_in_r <= in_alpha;
      gw_r       <= in_glyph_width;
      gh_r       <= in_glyph_height;
      adv_in_r   <= in_advance;
      bx_in_r    <= in_bearing_x;
      by_in_r    <= in_bearing_y;
      scol_r     <= in_surface_col;
      srow_r     <= in_surface_row;
    end
  end

  // Metric table: saturate width and height on write
  logic [DIM_W-1:0] w_sat, h_sat;
  logic [MW-1:0]    meta_wdata, meta_rdata;
  assign w_sat = (32'(gw_r) > GLYPH_MAX_DIM) ? DIM_W'(GLYPH_MAX_DIM) : DIM_W'(gw_r);
  assign h_sat = (32'(gh_r) > GLYPH_MAX_DIM) ? DIM_W'(GLYPH_MAX_DIM) : DIM_W'(gh_r);
  assign meta_wdata = {w_sat, h_sat, adv_in_r, bx_in_r, by_in_r};

  tbgb_ram #(.WIDTH(MW), .DEPTH(GLYPH_COUNT)) u_meta_ram (
    .clk     (clk),
    .we      (ctl.meta_we),
    .wr_addr (MA_W'(code_r)),
    .wr_data (meta_wdata),
    .rd_addr (MA_W'(code_r)),
    .rd_data (meta_rdata)
  );

  // Glyph bitmap store
  logic            gbm_we;
  logic [GA_W-1:0] gbm_waddr, gbm_raddr;
  logic [7:0]      gbm_rdata;
  assign gbm_we = ctl.glyph_we && (32'(gcol_r) < GLYPH_MAX_DIM)
                  && (32'(grow_r) < GLYPH_MAX_DIM);
  assign gbm_waddr = GA_W'((32'(code_r) * GLYPH_MAX_DIM + 32'(grow_r)) * GLYPH_MAX_DIM
                           + 32'(gcol_r));

  // Draw walk registers
  logic [DIM_W-1:0]  m_w_r, m_h_r, gx_r;
  logic [7:0]        m_adv_r, gy_r, gy0_r;
  logic signed [7:0] m_bx_r;
  logic [11:0]       top_r, dy_r;
  logic              wr_en_r;
  logic [SA_W-1:0]   wr_addr_r, clr_cnt_r;

  // Setup from the metric entry
  logic signed [10:0] leading;
  logic [7:0]         by_m;
  assign by_m    = meta_rdata[7:0];
  assign leading = $signed({3'b000, ascender_r}) - 11'(signed'(by_m));

  // Per-cycle draw decisions
  logic signed [11:0] sx, dx;
  logic               col_end, col_neg, col_brk, row_end, issue;
  assign sx      = 12'(m_bx_r) + $signed({{(12-DIM_W){1'b0}}, gx_r});
  assign dx      = $signed({2'b00, pen_position}) + sx;
  assign col_end = (gx_r >= m_w_r);
  assign col_neg = sx[11];
  assign col_brk = !col_neg && (dx >= $signed({1'b0, wlim}));
  assign row_end = (32'(gy_r) >= 32'(m_h_r)) || (dy_r >= {1'b0, hlim});
  assign issue   = !col_end && !col_brk && !col_neg && !row_end;
  assign gbm_raddr = GA_W'((32'(code_r) * GLYPH_MAX_DIM + 32'(gy_r)) * GLYPH_MAX_DIM
                           + 32'(gx_r));

  tbgb_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_glyph_ram (
    .clk     (clk),
    .we      (gbm_we),
    .wr_addr (gbm_waddr),
    .wr_data (alpha_in_r),
    .rd_addr (gbm_raddr),
    .rd_data (gbm_rdata)
  );

  // Advance the walk through the glyph pixels, down each column and then to the next column
  always_ff @(posedge clk) begin
    wr_en_r <= ctl.draw_step && issue;
    if (ctl.setup) begin
      m_w_r   <= meta_rdata[MW-1 -: DIM_W];
      m_h_r   <= meta_rdata[MW-DIM_W-1 -: DIM_W];
      m_adv_r <= meta_rdata[23:16];
      m_bx_r  <= meta_rdata[15:8];
      gx_r    <= '0;
      gy0_r   <= leading[10] ? 8'(-leading) : 8'd0;
      gy_r    <= leading[10] ? 8'(-leading) : 8'd0;
      top_r   <= (leading[10] ? 12'd0 : 12'(leading)) + {2'b00, line_top};
      dy_r    <= (leading[10] ? 12'd0 : 12'(leading)) + {2'b00, line_top};
    end else if (ctl.draw_step) begin
      if (issue) begin
        gy_r      <= gy_r + 8'd1;
        dy_r      <= dy_r + 12'd1;
        wr_addr_r <= SA_W'(32'(dy_r) * BOX_MAX_WIDTH + 32'(dx));
      end else begin
        gx_r <= gx_r + DIM_W'(1);
        gy_r <= gy0_r;
        dy_r <= top_r;
      end
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (ctl.clear_step) begin
      clr_cnt_r <= (clr_cnt_r == CLR_LAST) ? '0 : clr_cnt_r + SA_W'(1);
    end
  end

  // Surface store: clear writes zero, draw writes the fetched glyph pixel
  logic            surf_we;
  logic [SA_W-1:0] surf_waddr, surf_raddr;
  logic [7:0]      surf_wdata, surf_rdata;
  logic            in_box;
  assign surf_we    = ctl.clear_step || wr_en_r;
  assign surf_waddr = ctl.clear_step ? clr_cnt_r : wr_addr_r;
  assign surf_wdata = ctl.clear_step ? 8'd0 : gbm_rdata;
  assign in_box     = ({3'b000, scol_r} < wlim) && ({5'b00000, srow_r} < hlim);
  assign surf_raddr = SA_W'(32'(srow_r) * BOX_MAX_WIDTH + 32'(scol_r));

  tbgb_ram #(.WIDTH(8), .DEPTH(SDEPTH)) u_surf_ram (
    .clk     (clk),
    .we      (surf_we),
    .wr_addr (surf_waddr),
    .wr_data (surf_wdata),
    .rd_addr (surf_raddr),
    .rd_data (surf_rdata)
  );

  // Pen, line and read-back alpha
  logic [10:0] pen_sum, line_sum;
  assign pen_sum  = {1'b0, pen_position} + {3'b000, m_adv_r};
  assign line_sum = {1'b0, line_top} + {3'b000, line_height_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_position <= '0;
      line_top     <= '0;
      pixel_alpha  <= '0;
    end else begin
      if (ctl.latch_in) begin
        pixel_alpha <= '0;
      end else if (ctl.alpha_capture) begin
        pixel_alpha <= in_box ? surf_rdata : 8'd0;
      end
      if (ctl.text_reset) begin
        pen_position <= '0;
        line_top     <= '0;
      end else if (ctl.newline) begin
        pen_position <= '0;
        line_top     <= line_sum[10] ? POS_MAX : line_sum[9:0];
      end else if (ctl.pen_adv) begin
        pen_position <= pen_sum[10] ? POS_MAX : pen_sum[9:0];
      end
    end
  end

  assign stat.op           = op_r;
  assign stat.newline_code = (code_r == NEWLINE_CODE);
  assign stat.clear_last   = (clr_cnt_r == CLR_LAST);
  assign stat.draw_done    = col_end || col_brk;
endmodule

// ===== rtl/text_box_glyph_blitter.sv =====
`timescale 1ns / 1ps
// Glyph blitter for a text box: keeps a glyph atlas and a box surface.
// Input channel: drive in_* fields with start high; the transaction is taken
// at an edge where start is high and busy is low. Configuration writes
// (cfg_index, cfg_data) are taken whenever cfg_valid is high; issue them only
// while busy is low.
// Every transaction yields one result on the out_* ports, marked by a single
// cycle out_valid strobe. The receiver cannot stall; results must be taken.
// From accept to strobe, glyph pixel/metric writes, newline and unused ops
// pass through the execute and response states; a pixel read adds a read
// state; start text walks the whole surface clear; a drawn character goes
// through setup, the column walk and the pen advance, one glyph pixel per
// cycle through the glyph RAM read port into the surface RAM write port,
// with a step that writes nothing at each column change.
// One transaction is in flight at a time.
// Reset: busy stays high while the surface is cleared; pen, line and
// registers return to their reset values.
module text_box_glyph_blitter #(
  parameter int GLYPH_COUNT    = 128,
  parameter int GLYPH_MAX_DIM  = 32,
  parameter int BOX_MAX_WIDTH  = 256,
  parameter int BOX_MAX_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_op,
  input  logic [6:0]        in_code,
  input  logic [4:0]        in_glyph_col,
  input  logic [4:0]        in_glyph_row,
  input  logic [7:0]        in_alpha,
  input  logic [5:0]        in_glyph_width,
  input  logic [5:0]        in_glyph_height,
  input  logic [7:0]        in_advance,
  input  logic signed [7:0] in_bearing_x,
  input  logic signed [7:0] in_bearing_y,
  input  logic [7:0]        in_surface_col,
  input  logic [5:0]        in_surface_row,
  output logic              out_valid,
  output logic [7:0]        out_pixel_alpha,
  output logic [7:0]        out_pixel_level,
  output logic [9:0]        out_pen_position,
  output logic [9:0]        out_line_top,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data
);
  import tbgb_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tbgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tbgb_datapath #(
    .GLYPH_COUNT    (GLYPH_COUNT),
    .GLYPH_MAX_DIM  (GLYPH_MAX_DIM),
    .BOX_MAX_WIDTH  (BOX_MAX_WIDTH),
    .BOX_MAX_HEIGHT (BOX_MAX_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_op           (in_op),
    .in_code         (in_code),
    .in_glyph_col    (in_glyph_col),
    .in_glyph_row    (in_glyph_row),
    .in_alpha        (in_alpha),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_advance      (in_advance),
    .in_bearing_x    (in_bearing_x),
    .in_bearing_y    (in_bearing_y),
    .in_surface_col  (in_surface_col),
    .in_surface_row  (in_surface_row),
    .pixel_alpha     (out_pixel_alpha),
    .pen_position    (out_pen_position),
    .line_top        (out_line_top)
  );

  assign out_pixel_level = (out_pixel_alpha != 8'd0) ? LEVEL_ON : 8'd0;

  // A result is only strobed while a transaction is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // Each result is strobed for one cycle only
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe repeated");

  // The block goes idle right after a result
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
endmodule

// ===== dv/tb_text_box_glyph_blitter.sv =====
`timescale 1ns / 1ps
module tb_text_box_glyph_blitter;
  import tbgb_pkg::*;

  localparam int WDOG_LIMIT = 80000;

  typedef struct {
    logic [2:0]        op;
    logic [6:0]        code;
    logic [4:0]        gcol;
    logic [4:0]        grow;
    logic [7:0]        alpha;
    logic [5:0]        gw;
    logic [5:0]        gh;
    logic [7:0]        adv;
    logic signed [7:0] bx;
    logic signed [7:0] by;
    logic [7:0]        scol;
    logic [5:0]        srow;
  } blit_cmd_t;

  typedef struct {
    logic [7:0] alpha;
    logic [7:0] level;
    logic [9:0] pen;
    logic [9:0] line;
  } blit_res_t;

  typedef struct {
    blit_cmd_t cmd;
    bit        typed;
    blit_res_t res;
  } stim_row_t;

  logic clk, rst_n, start, busy;
  logic [2:0] in_op;
  logic [6:0] in_code;
  logic [4:0] in_glyph_col, in_glyph_row;
  logic [7:0] in_alpha, in_advance, in_surface_col;
  logic [5:0] in_glyph_width, in_glyph_height, in_surface_row;
  logic signed [7:0] in_bearing_x, in_bearing_y;
  logic out_valid;
  logic [7:0] out_pixel_alpha, out_pixel_level;
  logic [9:0] out_pen_position, out_line_top;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  text_box_glyph_blitter u_dut (.*);

  // Shadow copy of the atlas, surface, pen and registers
  logic [7:0] atlas_px [0:131071];
  bit         atlas_set [0:131071];
  int         gm_w [0:127], gm_h [0:127], gm_adv [0:127], gm_bx [0:127], gm_by [0:127];
  bit         gm_set [0:127];
  logic [7:0] surf [0:16383];
  int         pen, line, reg_w, reg_h, reg_asc, reg_lh;

  blit_res_t  pending_results [$];
  int         fail_cnt, accepted_cnt, result_cnt, draw_cnt, idle_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int sat_pos(int v);
    return v > 1023 ? 1023 : v;
  endfunction

  // A glyph may be drawn only when its metrics and every pixel it covers are known
  function automatic bit glyph_ready(int c);
    if (!gm_set[c]) return 0;
    for (int x = 0; x < gm_w[c]; x++)
      for (int y = 0; y < gm_h[c]; y++)
        if (!atlas_set[(c * 32 + y) * 32 + x]) return 0;
    return 1;
  endfunction

  function automatic blit_res_t blit_predict(blit_cmd_t c);
    blit_res_t r;
    int a, wl, hl, lead, top, gy0, sx, dx, dy, idx;
    a = 0;
    wl = reg_w > 256 ? 256 : reg_w;
    hl = reg_h > 64 ? 64 : reg_h;
    case (c.op)
      OP_GLYPH_PIXEL: begin
        idx = (c.code * 32 + c.grow) * 32 + c.gcol;
        atlas_px[idx] = c.alpha;
        atlas_set[idx] = 1;
      end
      OP_GLYPH_METRIC: begin
        gm_w[c.code] = c.gw > 32 ? 32 : c.gw;
        gm_h[c.code] = c.gh > 32 ? 32 : c.gh;
        gm_adv[c.code] = c.adv;
        gm_bx[c.code] = c.bx;
        gm_by[c.code] = c.by;
        gm_set[c.code] = 1;
      end
      OP_START_TEXT: begin
        foreach (surf[i]) surf[i] = '0;
        pen = 0;
        line = 0;
      end
      OP_DRAW_CHAR: begin
        if (c.code == NEWLINE_CODE) begin
          line = sat_pos(line + reg_lh);
          pen = 0;
        end else begin
          lead = reg_asc - gm_by[c.code];
          top = (lead > 0 ? lead : 0) + line;
          gy0 = lead < 0 ? -lead : 0;
          for (int gx = 0; gx < gm_w[c.code]; gx++) begin
            sx = gm_bx[c.code] + gx;
            if (sx >= 0) begin
              dx = pen + sx;
              if (dx >= wl) break;
              for (int gy = gy0; gy < gm_h[c.code]; gy++) begin
                dy = top + gy - gy0;
                if (dy >= hl) break;
                surf[dy * 256 + dx] = atlas_px[(c.code * 32 + gy) * 32 + gx];
              end
            end
          end
          pen = sat_pos(pen + gm_adv[c.code]);
        end
      end
      OP_READ_PIXEL: begin
        if (c.scol < wl && c.srow < hl) a = surf[c.srow * 256 + c.scol];
      end
      default: ;
    endcase
    r.alpha = 8'(a);
    r.level = a != 0 ? LEVEL_ON : 8'd0;
    r.pen = 10'(pen);
    r.line = 10'(line);
    return r;
  endfunction

  // Drive one transaction and hold it until the block takes it
  task automatic send_cmd(blit_cmd_t c, bit typed = 0, blit_res_t tres = '{default: 0});
    blit_res_t p;
    @(negedge clk);
    start = 1;
    in_op = c.op; in_code = c.code; in_glyph_col = c.gcol; in_glyph_row = c.grow;
    in_alpha = c.alpha; in_glyph_width = c.gw; in_glyph_height = c.gh;
    in_advance = c.adv; in_bearing_x = c.bx; in_bearing_y = c.by;
    in_surface_col = c.scol; in_surface_row = c.srow;
    do @(posedge clk); while (busy);
    p = blit_predict(c);
    pending_results.push_back(typed ? tres : p);
    accepted_cnt++;
    if (c.op == OP_DRAW_CHAR) draw_cnt++;
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    start = 0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    @(negedge clk);
    start = 0;
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = 9'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BOX_WIDTH:     reg_w = val & 9'h1ff;
      CFG_BOX_HEIGHT:    reg_h = val & 7'h7f;
      CFG_FONT_ASCENDER: reg_asc = val & 8'hff;
      default:           reg_lh = val & 8'hff;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic blit_cmd_t rand_cmd(int start_pct);
    blit_cmd_t c;
    int sel;
    logic [6:0] gset [5] = '{7'd33, 7'd34, 7'd35, 7'd36, 7'd127};
    c = '{op: OP_READ_PIXEL, code: 7'($urandom), gcol: 5'($urandom), grow: 5'($urandom),
          alpha: 8'($urandom), gw: 6'($urandom), gh: 6'($urandom), adv: 8'($urandom),
          bx: 8'($urandom), by: 8'($urandom), scol: 8'($urandom), srow: 6'($urandom)};
    sel = $urandom_range(0, 999);
    if (sel < start_pct) c.op = OP_START_TEXT;
    else if (sel < 300) begin
      c.op = OP_GLYPH_PIXEL;
      if (sel < 260) begin
        c.code = gset[$urandom_range(0, 3)];
        c.gcol = 5'($urandom_range(0, 7));
        c.grow = 5'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0) c.alpha = 8'd0;
      end
    end else if (sel < 400) begin
      c.op = OP_GLYPH_METRIC;
      c.code = gset[$urandom_range(0, 4)];
      if (sel < 380) begin
        c.gw = 6'($urandom_range(0, 8));
        c.gh = 6'($urandom_range(0, 8));
        c.adv = 8'($urandom_range(0, 12));
        c.bx = 8'($signed($urandom_range(0, 8)) - 3);
        c.by = 8'($signed($urandom_range(0, 24)) - 8);
      end
    end else if (sel < 700) begin
      c.op = OP_DRAW_CHAR;
      c.code = ($urandom_range(0, 5) == 0) ? NEWLINE_CODE : gset[$urandom_range(0, 4)];
      if (c.code != NEWLINE_CODE && !glyph_ready(c.code)) c.op = OP_READ_PIXEL;
    end else if (sel < 970) begin
      if (sel < 900) begin
        c.scol = 8'($urandom_range(0, 40));
        c.srow = 6'($urandom_range(0, 40));
      end
    end else c.op = 3'($urandom_range(5, 7));
    return c;
  endfunction

  // Compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    blit_res_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt++;
      end else begin
        e = pending_results.pop_front();
        result_cnt++;
        if (out_pixel_alpha !== e.alpha) begin
          $error("pixel_alpha exp %0d got %0d", e.alpha, out_pixel_alpha); fail_cnt++;
        end
        if (out_pixel_level !== e.level) begin
          $error("pixel_level exp %0d got %0d", e.level, out_pixel_level); fail_cnt++;
        end
        if (out_pen_position !== e.pen) begin
          $error("pen_position exp %0d got %0d", e.pen, out_pen_position); fail_cnt++;
        end
        if (out_line_top !== e.line) begin
          $error("line_top exp %0d got %0d", e.line, out_line_top); fail_cnt++;
        end
      end
    end
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("text_box_glyph_blitter test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    blit_cmd_t c, z;
    int burst;
    int cfg_set [6][4] = '{'{256, 64, 0, 16}, '{0, 0, 255, 255}, '{511, 127, 10, 255},
                           '{20, 12, 4, 3}, '{1, 1, 0, 0}, '{40, 30, 6, 9}};
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = CFG_BOX_WIDTH; cfg_data = '0;
    in_op = '0; in_code = '0; in_glyph_col = '0; in_glyph_row = '0; in_alpha = '0;
    in_glyph_width = '0; in_glyph_height = '0; in_advance = '0; in_bearing_x = '0;
    in_bearing_y = '0; in_surface_col = '0; in_surface_row = '0;
    fail_cnt = 0; accepted_cnt = 0; result_cnt = 0; draw_cnt = 0;
    foreach (atlas_set[i]) atlas_set[i] = 0;
    foreach (gm_set[i]) gm_set[i] = 0;
    foreach (surf[i]) surf[i] = '0;
    pen = 0; line = 0; reg_w = 256; reg_h = 64; reg_asc = 0; reg_lh = 16;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed part: typed results where obvious, predictor elsewhere
    z = '{op: OP_READ_PIXEL, default: 0};
    rows.push_back('{z, 1, '{0, 0, 0, 0}});
    c = z; c.op = 3'd5; rows.push_back('{c, 1, '{0, 0, 0, 0}});
    c = z; c.op = 3'd7; rows.push_back('{c, 1, '{0, 0, 0, 0}});
    c = z; c.op = OP_DRAW_CHAR; c.code = NEWLINE_CODE; rows.push_back('{c, 1, '{0, 0, 0, 16}});
    c = z; c.op = OP_START_TEXT; rows.push_back('{c, 1, '{0, 0, 0, 0}});
    c = z; c.op = OP_GLYPH_METRIC; c.code = 127; c.gw = 63; c.gh = 63; c.adv = 255;
    c.bx = -128; c.by = 127; rows.push_back('{c, 1, '{0, 0, 0, 0}});
    c = z; c.op = OP_GLYPH_PIXEL; c.code = 127; c.gcol = 31; c.grow = 31; c.alpha = 255;
    rows.push_back('{c, 1, '{0, 0, 0, 0}});
    c = z; c.op = OP_GLYPH_METRIC; c.code = 33; c.gw = 8; c.gh = 8; c.adv = 255;
    c.bx = -3; c.by = 5; rows.push_back('{c, 0, '{0, 0, 0, 0}});
    c = z; c.op = OP_DRAW_CHAR; c.code = 33;
    repeat (5) rows.push_back('{c, 0, '{0, 0, 0, 0}});
    c = z; c.scol = 2; rows.push_back('{c, 0, '{0, 0, 0, 0}});
    c = z; c.scol = 255; c.srow = 63; rows.push_back('{c, 0, '{0, 0, 0, 0}});
    c = z; c.op = OP_START_TEXT; rows.push_back('{c, 0, '{0, 0, 0, 0}});
    c = z; c.op = OP_GLYPH_METRIC; c.code = 34; c.gw = 8; c.gh = 8; c.adv = 8;
    c.bx = 127; c.by = -128; rows.push_back('{c, 0, '{0, 0, 0, 0}});
    c = z; c.op = OP_DRAW_CHAR; c.code = 34; rows.push_back('{c, 0, '{0, 0, 0, 0}});
    c = z; c.op = OP_GLYPH_METRIC; c.code = 35; c.gw = 8; c.gh = 8; c.adv = 4;
    c.bx = 0; c.by = 0; rows.push_back('{c, 0, '{0, 0, 0, 0}});
    c = z; c.op = OP_DRAW_CHAR; c.code = 35; rows.push_back('{c, 0, '{0, 0, 0, 0}});
    c = z; c.scol = 12; c.srow = 0; rows.push_back('{c, 0, '{0, 0, 0, 0}});

    // Fill four 8x8 glyphs so they can be drawn, then walk the table
    for (int g = 33; g <= 36; g++)
      for (int y = 0; y < 8; y++)
        for (int x = 0; x < 8; x++) begin
          c = z; c.op = OP_GLYPH_PIXEL; c.code = 7'(g); c.gcol = 5'(x); c.grow = 5'(y);
          c.alpha = (x + y) % 3 == 0 ? 8'd0 : 8'($urandom);
          if (g == 33 && x == 0 && y == 0) begin
            send_cmd(c, 1, '{0, 0, 0, 0});
          end else send_cmd(c);
        end
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].res);
    idle_gap(1);
    drain();

    // Random part over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_BOX_WIDTH, cfg_set[ph][0]);
      write_reg(CFG_BOX_HEIGHT, cfg_set[ph][1]);
      write_reg(CFG_FONT_ASCENDER, cfg_set[ph][2]);
      write_reg(CFG_LINE_HEIGHT, cfg_set[ph][3]);
      burst = 0;
      for (int n = 0; n < 50; n++) begin
        send_cmd(rand_cmd(n == 0 ? 1000 : 8));
        if (burst == 0) begin
          burst = $urandom_range(1, 16);
          if (ph != 2) idle_gap($urandom_range(1, 20));
        end else burst--;
        if (n == 25 && ph == 3) begin
          idle_gap(1);
          drain();
        end
      end
      idle_gap(1);
      drain();
    end

    $display("Accepted %0d transactions (%0d character draws), checked %0d results,",
             accepted_cnt, draw_cnt, result_cnt);
    $display("across six register settings including zero and oversized box sizes.");
    if (fail_cnt == 0) begin
      $display("text_box_glyph_blitter test passed");
    end else begin
      $display("text_box_glyph_blitter test failed");
    end
    $finish;
  end

endmodule
